// File: rtl/core/matrix_keypad_scan_repeat_top_assert.svh
// ----------------------------------------------------------------------------
// Keypad scanner assertion macros
// Concurrent assertion wrappers used by the keypad scanner datapath.
// ----------------------------------------------------------------------------
`ifndef MATRIX_KEYPAD_SCAN_REPEAT_TOP_ASSERT_SVH
`define MATRIX_KEYPAD_SCAN_REPEAT_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Checks that the consequent holds in the same cycle as the antecedent.
`define KPD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keypad scanner assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define KPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keypad scanner assertion failed");

`else

`define KPD_ASSERT_SAME(label, clk, rst, ante, cons)
`define KPD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/kpd_pkg.sv
// ----------------------------------------------------------------------------
// Keypad scanner package
// Shared types, register codes, reset values and the key code map.
// ----------------------------------------------------------------------------
package kpd_pkg;

   // Configuration register widths and reset values.
   localparam int FIRST_DELAY_W = 24;
   localparam int REPEAT_STEP_W = 16;
   localparam int HOLD_INC_W    = 8;

   localparam logic [FIRST_DELAY_W-1:0] FIRST_DELAY_RST = 24'd1000;
   localparam logic [REPEAT_STEP_W-1:0] REPEAT_STEP_RST = 16'd200;
   localparam logic [HOLD_INC_W-1:0]    HOLD_INC_RST    = 8'd4;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes on the configuration port.
   typedef enum logic [1:0] {
      REG_FIRST_DELAY = 2'd0,
      REG_REPEAT_STEP = 2'd1,
      REG_HOLD_INC    = 2'd2
   } kpd_reg_type;

   typedef struct packed {
      logic [FIRST_DELAY_W-1:0] first_delay;
      logic [REPEAT_STEP_W-1:0] repeat_step;
      logic [HOLD_INC_W-1:0]    hold_inc;
   } kpd_cfg_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_PRESS,
      ST_REPEAT,
      ST_FINISH
   } kpd_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic rd;
      logic eval;
      logic push;
      logic push_rep;
      logic advance;
      logic finish;
   } kpd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic drive;
      logic press;
      logic rep;
      logic last_key;
      logic can_push;
      logic out_free;
   } kpd_stat_type;

   // Key codes of the 4x4 map, row-major.
   localparam logic [7:0] KEY_MAP [16] = '{
      8'h31, 8'h32, 8'h33, 8'h26,
      8'h34, 8'h35, 8'h36, 8'h25,
      8'h37, 8'h38, 8'h39, 8'h28,
      8'h30, 8'h1B, 8'h0D, 8'h27
   };

   // Keys outside the 4x4 map have code zero.
   function automatic logic [7:0] key_code(input logic [2:0] row, input logic [2:0] col);
      logic [7:0] code;
      code = 8'h00;
      if (!row[2] && !col[2]) begin
         code = KEY_MAP[{row[1:0], col[1:0]}];
      end
      return code;
   endfunction

endpackage

// File: rtl/core/kpd_csr.sv
// ----------------------------------------------------------------------------
// Keypad scanner register block
// APB-style configuration registers for repeat delay, step and hold increment.
// ----------------------------------------------------------------------------
module kpd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [kpd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [kpd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [kpd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready,
   output kpd_pkg::kpd_cfg_type               cfg
);

   kpd_pkg::kpd_cfg_type cfg_ff;
   kpd_pkg::kpd_cfg_type cfg_in;
   kpd_pkg::kpd_reg_type reg_sel;
   logic                 wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = kpd_pkg::kpd_reg_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   // Register write decode; writes beyond the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            kpd_pkg::REG_FIRST_DELAY: begin
               cfg_in.first_delay = csr_pwdata[kpd_pkg::FIRST_DELAY_W-1:0];
            end
            kpd_pkg::REG_REPEAT_STEP: begin
               cfg_in.repeat_step = csr_pwdata[kpd_pkg::REPEAT_STEP_W-1:0];
            end
            kpd_pkg::REG_HOLD_INC: begin
               cfg_in.hold_inc = csr_pwdata[kpd_pkg::HOLD_INC_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_delay <= kpd_pkg::FIRST_DELAY_RST;
         cfg_ff.repeat_step <= kpd_pkg::REPEAT_STEP_RST;
         cfg_ff.hold_inc    <= kpd_pkg::HOLD_INC_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux.
   always_comb begin
      case (reg_sel)
         kpd_pkg::REG_FIRST_DELAY: begin
            csr_prdata = kpd_pkg::CSR_DATA_W'(cfg_ff.first_delay);
         end
         kpd_pkg::REG_REPEAT_STEP: begin
            csr_prdata = kpd_pkg::CSR_DATA_W'(cfg_ff.repeat_step);
         end
         kpd_pkg::REG_HOLD_INC: begin
            csr_prdata = kpd_pkg::CSR_DATA_W'(cfg_ff.hold_inc);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/kpd_ctrl.sv
// ----------------------------------------------------------------------------
// Keypad scanner controller
// Sequences the per-key read, update and event emission steps of each word.
// ----------------------------------------------------------------------------
module kpd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kpd_pkg::kpd_stat_type stat,
   output kpd_pkg::kpd_cmd_type  cmd
);

   kpd_pkg::kpd_state_type state_ff;
   kpd_pkg::kpd_state_type state_in;
   logic                   press_done;
   logic                   rep_done;

   // A pending event step completes when there is no event or it can be queued.
   assign press_done = !stat.press || stat.can_push;
   assign rep_done   = !stat.rep || stat.can_push;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kpd_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = kpd_pkg::ST_READ;
            end
         end
         kpd_pkg::ST_READ: begin
            state_in = kpd_pkg::ST_EVAL;
         end
         kpd_pkg::ST_EVAL: begin
            if (stat.drive) begin
               state_in = kpd_pkg::ST_PRESS;
            end else if (stat.last_key) begin
               state_in = kpd_pkg::ST_FINISH;
            end else begin
               state_in = kpd_pkg::ST_READ;
            end
         end
         kpd_pkg::ST_PRESS: begin
            if (press_done) begin
               state_in = kpd_pkg::ST_REPEAT;
            end
         end
         kpd_pkg::ST_REPEAT: begin
            if (rep_done) begin
               state_in = stat.last_key ? kpd_pkg::ST_FINISH : kpd_pkg::ST_READ;
            end
         end
         kpd_pkg::ST_FINISH: begin
            if (stat.out_free) begin
               state_in = kpd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kpd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kpd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs.
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         kpd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         kpd_pkg::ST_READ: begin
            cmd.rd = 1'b1;
         end
         kpd_pkg::ST_EVAL: begin
            cmd.eval    = 1'b1;
            cmd.advance = !stat.drive && !stat.last_key;
         end
         kpd_pkg::ST_PRESS: begin
            cmd.push = stat.press && stat.can_push;
         end
         kpd_pkg::ST_REPEAT: begin
            cmd.push     = stat.rep && stat.can_push;
            cmd.push_rep = 1'b1;
            cmd.advance  = rep_done && !stat.last_key;
         end
         kpd_pkg::ST_FINISH: begin
            cmd.finish = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: rtl/core/kpd_dp.sv
// ----------------------------------------------------------------------------
// Keypad scanner datapath
// Per-key state memories, debounce and repeat update, pending event and
// result registers.
// ----------------------------------------------------------------------------
`include "matrix_keypad_scan_repeat_top_assert.svh"

module kpd_dp #(
   parameter int ROWS             = 4,
   parameter int COLUMNS          = 4,
   parameter int DEBOUNCE_SAMPLES = 4,
   parameter int TIME_WIDTH       = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_func,
   input  logic [3:0]            req_columns,
   input  kpd_pkg::kpd_cfg_type  cfg,
   input  kpd_pkg::kpd_cmd_type  cmd,
   output kpd_pkg::kpd_stat_type stat,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_row_select,
   output logic                  rsp_event_valid,
   output logic [7:0]            rsp_key_code,
   output logic [3:0]            rsp_key_index,
   output logic                  rsp_is_repeat,
   output logic                  rsp_last
);

   localparam int NKEYS = ROWS * COLUMNS;
   localparam int KW    = (NKEYS > 1) ? $clog2(NKEYS) : 1;
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CLW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int DS    = DEBOUNCE_SAMPLES;
   localparam int TW    = TIME_WIDTH;
   localparam int DW    = (TW > kpd_pkg::FIRST_DELAY_W) ? TW : kpd_pkg::FIRST_DELAY_W;

   localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};
   localparam logic [TW-1:0] THR_RST  = TW'(kpd_pkg::FIRST_DELAY_RST);

   // Per-key state memories; an entry whose valid bit is clear reads as reset.
   logic [DS-1:0] hist_mem [NKEYS];
   logic          prs_mem  [NKEYS];
   logic          rpt_mem  [NKEYS];
   logic [TW-1:0] hold_mem [NKEYS];
   logic [TW-1:0] thr_mem  [NKEYS];
   logic [NKEYS-1:0] key_vld_ff;

   logic [DS-1:0] rd_hist_ff;
   logic          rd_prs_ff;
   logic          rd_rpt_ff;
   logic [TW-1:0] rd_hold_ff;
   logic [TW-1:0] rd_thr_ff;
   logic          rd_vld_ff;

   // Word and position registers.
   logic           func_ff;
   logic [3:0]     cols_ff;
   logic [KW-1:0]  key_ptr_ff;
   logic [KW-1:0]  key_ptr_in;
   logic [CLW-1:0] col_ff;
   logic [CLW-1:0] col_in;
   logic [RW-1:0]  row_cnt_ff;
   logic [RW-1:0]  row_cnt_in;
   logic [RW-1:0]  current_row_ff;
   logic [RW-1:0]  current_row_in;
   logic           press_ff;
   logic           rep_ff;

   // Pending event and result registers.
   logic       pend_valid_ff;
   logic       pend_valid_in;
   logic [7:0] pend_code_ff;
   logic [3:0] pend_index_ff;
   logic       pend_rep_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [1:0] rsp_row_ff;
   logic       rsp_evt_ff;
   logic [7:0] rsp_code_ff;
   logic [3:0] rsp_index_ff;
   logic       rsp_rep_ff;
   logic       rsp_last_ff;

   // Update logic signals.
   logic [DS-1:0] cur_hist;
   logic          cur_prs;
   logic          cur_rpt;
   logic [TW-1:0] cur_hold;
   logic [TW-1:0] cur_thr;
   logic [DS-1:0] new_hist;
   logic          new_prs;
   logic          new_rpt;
   logic [TW-1:0] new_hold;
   logic [TW-1:0] new_thr;
   logic          press_evt;
   logic          rep_evt;
   logic          col_bit;
   logic [TW:0]   hold_sum;
   logic [TW:0]   thr_sum;
   logic [TW-1:0] init_thr;
   logic          last_col;
   logic          last_key;
   logic          out_free;
   logic          load_out;

   assign last_col = (col_ff == CLW'(COLUMNS - 1));
   assign last_key = func_ff ? (key_ptr_ff == KW'(NKEYS - 1)) : last_col;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load_out = (cmd.push && pend_valid_ff) || cmd.finish;

   assign stat.drive    = func_ff;
   assign stat.press    = press_ff;
   assign stat.rep      = rep_ff;
   assign stat.last_key = last_key;
   assign stat.can_push = !pend_valid_ff || out_free;
   assign stat.out_free = out_free;

   // Latch the word and step through the keys it covers.
   always_comb begin
      key_ptr_in = key_ptr_ff;
      col_in     = col_ff;
      row_cnt_in = row_cnt_ff;
      if (cmd.start) begin
         key_ptr_in = req_func ? '0 : (KW'(current_row_ff) * KW'(COLUMNS));
         col_in     = '0;
         row_cnt_in = '0;
      end else if (cmd.advance) begin
         key_ptr_in = key_ptr_ff + KW'(1);
         if (last_col) begin
            col_in     = '0;
            row_cnt_in = row_cnt_ff + RW'(1);
         end else begin
            col_in = col_ff + CLW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         func_ff <= req_func;
         cols_ff <= req_columns;
      end
      key_ptr_ff <= key_ptr_in;
      col_ff     <= col_in;
      row_cnt_ff <= row_cnt_in;
   end

   // Memory read port, registered.
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_hist_ff <= hist_mem[key_ptr_ff];
         rd_prs_ff  <= prs_mem[key_ptr_ff];
         rd_rpt_ff  <= rpt_mem[key_ptr_ff];
         rd_hold_ff <= hold_mem[key_ptr_ff];
         rd_thr_ff  <= thr_mem[key_ptr_ff];
         rd_vld_ff  <= key_vld_ff[key_ptr_ff];
      end
   end

   // Effective key state, substituting reset values for untouched keys.
   always_comb begin
      cur_hist = rd_vld_ff ? rd_hist_ff : {DS{1'b1}};
      cur_prs  = rd_vld_ff ? rd_prs_ff : 1'b1;
      cur_rpt  = rd_vld_ff ? rd_rpt_ff : 1'b1;
      cur_hold = rd_vld_ff ? rd_hold_ff : '0;
      cur_thr  = rd_vld_ff ? rd_thr_ff : THR_RST;
   end

   // Saturating sums and the clamped first repeat delay.
   assign hold_sum = {1'b0, cur_hold} + (TW + 1)'(cfg.hold_inc);
   assign thr_sum  = {1'b0, cur_thr} + (TW + 1)'(cfg.repeat_step);
   assign init_thr = (DW'(cfg.first_delay) > DW'(TIME_MAX)) ? TIME_MAX
                                                            : TW'(cfg.first_delay);

   // Columns beyond the four pins always read high.
   assign col_bit = (32'(col_ff) < 4) ? cols_ff[2'(col_ff)] : 1'b1;

   // Debounce update on a scan tick, event detection on a drive pass.
   always_comb begin
      new_hist  = cur_hist;
      new_prs   = cur_prs;
      new_rpt   = cur_rpt;
      new_hold  = cur_hold;
      new_thr   = cur_thr;
      press_evt = 1'b0;
      rep_evt   = 1'b0;
      if (!func_ff) begin
         new_hist = {cur_hist[DS-2:0], col_bit};
         if (new_hist == '0) begin
            new_prs  = 1'b0;
            new_hold = hold_sum[TW] ? TIME_MAX : hold_sum[TW-1:0];
         end else if (new_hist == {DS{1'b1}}) begin
            new_prs  = 1'b1;
            new_hold = '0;
         end
      end else begin
         press_evt = (cur_rpt != cur_prs) && !cur_prs;
         new_rpt   = cur_prs;
         if (cur_hold != '0) begin
            if (cur_hold >= cur_thr) begin
               rep_evt = 1'b1;
               new_thr = thr_sum[TW] ? TIME_MAX : thr_sum[TW-1:0];
            end
         end else begin
            new_thr = init_thr;
         end
      end
   end

   // Memory write port.
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         hist_mem[key_ptr_ff] <= new_hist;
         prs_mem[key_ptr_ff]  <= new_prs;
         rpt_mem[key_ptr_ff]  <= new_rpt;
         hold_mem[key_ptr_ff] <= new_hold;
         thr_mem[key_ptr_ff]  <= new_thr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         press_ff <= press_evt;
         rep_ff   <= rep_evt;
      end
   end

   // The driven row advances at the last column of a scan tick.
   always_comb begin
      current_row_in = current_row_ff;
      if (cmd.eval && !func_ff && last_col) begin
         current_row_in = (current_row_ff == RW'(ROWS - 1)) ? '0
                                                            : current_row_ff + RW'(1);
      end
   end

   // An event waits in the pending slot until the next one or the end of the
   // word shows whether it is the final result.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (cmd.push) begin
         pend_valid_in = 1'b1;
      end else if (cmd.finish) begin
         pend_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_vld_ff     <= '0;
         current_row_ff <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.eval) begin
            key_vld_ff[key_ptr_ff] <= 1'b1;
         end
         current_row_ff <= current_row_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Pending and result payload.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         pend_code_ff  <= kpd_pkg::key_code(3'(row_cnt_ff), 3'(col_ff));
         pend_index_ff <= 4'(key_ptr_ff);
         pend_rep_ff   <= cmd.push_rep;
      end
      if (load_out) begin
         rsp_row_ff   <= 2'(current_row_ff);
         rsp_evt_ff   <= pend_valid_ff;
         rsp_code_ff  <= pend_valid_ff ? pend_code_ff : 8'h00;
         rsp_index_ff <= pend_valid_ff ? pend_index_ff : 4'h0;
         rsp_rep_ff   <= pend_valid_ff && pend_rep_ff;
         rsp_last_ff  <= cmd.finish;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_select  = rsp_row_ff;
   assign rsp_event_valid = rsp_evt_ff;
   assign rsp_key_code    = rsp_code_ff;
   assign rsp_key_index   = rsp_index_ff;
   assign rsp_is_repeat   = rsp_rep_ff;
   assign rsp_last        = rsp_last_ff;

   // Moving the pending event out must never overwrite an untaken result.
   `KPD_ASSERT_SAME(a_push_out_free, clock, reset, cmd.push && pend_valid_ff, out_free)
   // The closing word of an item always lands in the result register.
   `KPD_ASSERT_NEXT(a_finish_loads, clock, reset, cmd.finish, rsp_valid_ff && rsp_last_ff)
   // Nothing stays pending once an item has closed.
   `KPD_ASSERT_NEXT(a_finish_clears, clock, reset, cmd.finish, !pend_valid_ff)
   // A key is updated only from freshly read memory data.
   `KPD_ASSERT_SAME(a_eval_after_read, clock, reset, cmd.eval, $past(cmd.rd))

endmodule

// File: rtl/core/matrix_keypad_scan_repeat_top.sv
// Sequencing: one item at a time; every key costs a memory read and an update step,
// and on a drive pass the press and repeat event steps as well.
// Reset: all keys read as released with zero hold time and a threshold of 1000 through
// per-key valid bits, the driven row returns to zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Keypad scanner top level
// 4x4 matrix keypad scanner with debounce and auto repeat: register block,
// controller and datapath.
// ----------------------------------------------------------------------------
module matrix_keypad_scan_repeat_top #(
   parameter int ROWS             = 4,
   parameter int COLUMNS          = 4,
   parameter int DEBOUNCE_SAMPLES = 4,
   parameter int TIME_WIDTH       = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_func,
   input  logic [3:0]                     req_columns,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_row_select,
   output logic                           rsp_event_valid,
   output logic [7:0]                     rsp_key_code,
   output logic [3:0]                     rsp_key_index,
   output logic                           rsp_is_repeat,
   output logic                           rsp_last,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [kpd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [kpd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [kpd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   kpd_pkg::kpd_cfg_type  cfg;
   kpd_pkg::kpd_cmd_type  cmd;
   kpd_pkg::kpd_stat_type stat;

   // Configuration registers.
   kpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Sequencer.
   kpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Key state and result path.
   kpd_dp #(
      .ROWS             (ROWS),
      .COLUMNS          (COLUMNS),
      .DEBOUNCE_SAMPLES (DEBOUNCE_SAMPLES),
      .TIME_WIDTH       (TIME_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_func),
      .req_columns     (req_columns),
      .cfg             (cfg),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_row_select  (rsp_row_select),
      .rsp_event_valid (rsp_event_valid),
      .rsp_key_code    (rsp_key_code),
      .rsp_key_index   (rsp_key_index),
      .rsp_is_repeat   (rsp_is_repeat),
      .rsp_last        (rsp_last)
   );

endmodule

// File: test/tb_matrix_keypad_scan_repeat_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scanner testbench
// Sends scan ticks and drive passes to the 4x4 keypad scanner and predicts
// every result word from a behavioral model of the debounce, press edge and
// auto repeat logic. Each word is checked field by field. The registers are
// reprogrammed and read back between phases, with random idle cycles on both
// channels.
// ----------------------------------------------------------------------------
module tb_matrix_keypad_scan_repeat_top;

   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 2;
   localparam int MAX_GAP       = 18;
   localparam int SETTLE_CYCLES = 80;
   localparam int IDLE_LIMIT    = 3000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 56;
   localparam int NUM_KEYS      = 16;
   localparam int UNMAPPED_REG  = 3;

   localparam logic FUNC_SCAN  = 1'b0;
   localparam logic FUNC_DRIVE = 1'b1;

   localparam logic [23:0] TIME_SAT = 24'hFF_FFFF;

   // Key codes in row-major order.
   localparam logic [7:0] KEYPAD_CODES [NUM_KEYS] = '{
      8'h31, 8'h32, 8'h33, 8'h26,
      8'h34, 8'h35, 8'h36, 8'h25,
      8'h37, 8'h38, 8'h39, 8'h28,
      8'h30, 8'h1B, 8'h0D, 8'h27
   };

   typedef struct packed {
      logic [1:0] row_select;
      logic       event_valid;
      logic [7:0] key_code;
      logic [3:0] key_index;
      logic       is_repeat;
      logic       last;
   } keypad_word_type;

   // One row of the directed table; want_row is used only for typed rows.
   typedef struct packed {
      logic       func;
      logic [3:0] columns;
      logic       typed;
      logic [1:0] want_row;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 25;

   // Reset state first, then all sixteen keys pressed together, then mixed
   // samples on columns one and three while columns zero and two stay held.
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{FUNC_SCAN,  4'hF, 1'b1, 2'd1},
      '{FUNC_DRIVE, 4'h0, 1'b1, 2'd1},
      '{FUNC_SCAN,  4'h0, 1'b0, 2'd0}, '{FUNC_SCAN,  4'h0, 1'b0, 2'd0},
      '{FUNC_SCAN,  4'h0, 1'b0, 2'd0}, '{FUNC_SCAN,  4'h0, 1'b0, 2'd0},
      '{FUNC_SCAN,  4'h0, 1'b0, 2'd0}, '{FUNC_SCAN,  4'h0, 1'b0, 2'd0},
      '{FUNC_SCAN,  4'h0, 1'b0, 2'd0}, '{FUNC_SCAN,  4'h0, 1'b0, 2'd0},
      '{FUNC_SCAN,  4'h0, 1'b0, 2'd0}, '{FUNC_SCAN,  4'h0, 1'b0, 2'd0},
      '{FUNC_SCAN,  4'h0, 1'b0, 2'd0}, '{FUNC_SCAN,  4'h0, 1'b0, 2'd0},
      '{FUNC_SCAN,  4'h0, 1'b0, 2'd0}, '{FUNC_SCAN,  4'h0, 1'b0, 2'd0},
      '{FUNC_SCAN,  4'h0, 1'b0, 2'd0}, '{FUNC_SCAN,  4'h0, 1'b0, 2'd0},
      '{FUNC_DRIVE, 4'h0, 1'b0, 2'd0},
      '{FUNC_DRIVE, 4'hF, 1'b1, 2'd1},
      '{FUNC_SCAN,  4'hA, 1'b0, 2'd0}, '{FUNC_SCAN,  4'hA, 1'b0, 2'd0},
      '{FUNC_SCAN,  4'hA, 1'b0, 2'd0}, '{FUNC_SCAN,  4'hA, 1'b0, 2'd0},
      '{FUNC_DRIVE, 4'hF, 1'b1, 2'd1}
   };

   // Clock, reset and ports of the block.
   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           req_valid   = 1'b0;
   logic                           req_ready;
   logic                           req_func    = 1'b0;
   logic [3:0]                     req_columns = 4'h0;
   logic                           rsp_valid;
   logic                           rsp_ready   = 1'b0;
   logic [1:0]                     rsp_row_select;
   logic                           rsp_event_valid;
   logic [7:0]                     rsp_key_code;
   logic [3:0]                     rsp_key_index;
   logic                           rsp_is_repeat;
   logic                           rsp_last;
   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [kpd_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [kpd_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [kpd_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // Scanner state as the testbench predicts it.
   logic [3:0]  scan_history [NUM_KEYS];
   logic        key_up       [NUM_KEYS];
   logic        key_seen_up  [NUM_KEYS];
   logic [23:0] held_for     [NUM_KEYS];
   logic [23:0] repeat_at    [NUM_KEYS];
   logic [1:0]  driven_row;
   logic [23:0] cfg_first_delay;
   logic [15:0] cfg_repeat_step;
   logic [7:0]  cfg_hold_inc;

   keypad_word_type expected_words [$];
   keypad_word_type pending;
   logic [15:0]     keys_held;
   bit              sender_quiet   = 1'b0;
   bit              receiver_quiet = 1'b0;
   int              fail_count     = 0;
   int              idle_cycles    = 0;
   int              rsp_hold       = 0;
   int unsigned     rsp_gap;

   matrix_keypad_scan_repeat_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_columns     (req_columns),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_row_select  (rsp_row_select),
      .rsp_event_valid (rsp_event_valid),
      .rsp_key_code    (rsp_key_code),
      .rsp_key_index   (rsp_key_index),
      .rsp_is_repeat   (rsp_is_repeat),
      .rsp_last        (rsp_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // The run ends if no word moves on any port for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // The receiver stalls for a random number of cycles after each word.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         rsp_gap = receiver_quiet ? 0 : $urandom_range(0, MAX_GAP);
         rsp_hold  <= rsp_gap;
         rsp_ready <= (rsp_gap == 0);
      end else if (rsp_hold > 1) begin
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_hold  <= 0;
         rsp_ready <= 1'b1;
      end
   end

   task automatic compare_field(input string name, input logic [31:0] want_v,
                                input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
         fail_count++;
      end
   endtask

   // Each result word is matched against the oldest predicted word.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("result word arrived with no prediction pending");
            fail_count++;
         end else begin
            pending = expected_words.pop_front();
            compare_field("row_select", 32'(pending.row_select), 32'(rsp_row_select));
            compare_field("event_valid", 32'(pending.event_valid), 32'(rsp_event_valid));
            compare_field("key_code", 32'(pending.key_code), 32'(rsp_key_code));
            compare_field("key_index", 32'(pending.key_index), 32'(rsp_key_index));
            compare_field("is_repeat", 32'(pending.is_repeat), 32'(rsp_is_repeat));
            compare_field("last", 32'(pending.last), 32'(rsp_last));
         end
      end
   end

   function automatic logic [23:0] sat_time_add(input logic [23:0] a, input logic [23:0] b);
      logic [24:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[24] ? TIME_SAT : sum[23:0];
   endfunction

   function automatic keypad_word_type idle_word(input logic [1:0] row_sel);
      keypad_word_type w;
      w            = '0;
      w.row_select = row_sel;
      w.last       = 1'b1;
      return w;
   endfunction

   function automatic logic [31:0] register_value(input int index);
      logic [31:0] value;
      value = '0;
      case (index)
         kpd_pkg::REG_FIRST_DELAY: value = {8'd0, cfg_first_delay};
         kpd_pkg::REG_REPEAT_STEP: value = {16'd0, cfg_repeat_step};
         kpd_pkg::REG_HOLD_INC:    value = {24'd0, cfg_hold_inc};
         default:                  value = '0;
      endcase
      return value;
   endfunction

   task automatic reset_scanner_model();
      int k;
      cfg_first_delay = kpd_pkg::FIRST_DELAY_RST;
      cfg_repeat_step = kpd_pkg::REPEAT_STEP_RST;
      cfg_hold_inc    = kpd_pkg::HOLD_INC_RST;
      for (k = 0; k < NUM_KEYS; k++) begin
         scan_history[k] = 4'hF;
         key_up[k]       = 1'b1;
         key_seen_up[k]  = 1'b1;
         held_for[k]     = '0;
         repeat_at[k]    = kpd_pkg::FIRST_DELAY_RST;
      end
      driven_row = 2'd0;
   endtask

   // Advances the predicted state by one accepted word and, when record is
   // set, queues the result words it causes.
   task automatic predict_item(input logic func, input logic [3:0] cols, input bit record);
      keypad_word_type produced [$];
      keypad_word_type word;
      logic [3:0]      hist;
      int              k;
      int              c;
      if (func == FUNC_SCAN) begin
         // Shift one sample into each key of the driven row.
         for (c = 0; c < 4; c++) begin
            k    = driven_row * 4 + c;
            hist = {scan_history[k][2:0], cols[c]};
            scan_history[k] = hist;
            if (hist == 4'b0000) begin
               key_up[k]   = 1'b0;
               held_for[k] = sat_time_add(held_for[k], 24'(cfg_hold_inc));
            end else if (hist == 4'b1111) begin
               key_up[k]   = 1'b1;
               held_for[k] = '0;
            end
         end
         driven_row = driven_row + 2'd1;
         produced.push_back(idle_word(driven_row));
      end else begin
         // Walk the keys in row-major order; press comes before repeat.
         for (k = 0; k < NUM_KEYS; k++) begin
            word             = '0;
            word.row_select  = driven_row;
            word.event_valid = 1'b1;
            word.key_code    = KEYPAD_CODES[k];
            word.key_index   = k[3:0];
            if (key_seen_up[k] != key_up[k]) begin
               if (!key_up[k]) begin
                  produced.push_back(word);
               end
               key_seen_up[k] = key_up[k];
            end
            if (held_for[k] != '0) begin
               if (held_for[k] >= repeat_at[k]) begin
                  word.is_repeat = 1'b1;
                  produced.push_back(word);
                  repeat_at[k] = sat_time_add(repeat_at[k], 24'(cfg_repeat_step));
               end
            end else begin
               repeat_at[k] = cfg_first_delay;
            end
         end
         if (produced.size() == 0) begin
            produced.push_back(idle_word(driven_row));
         end else begin
            word      = produced.pop_back();
            word.last = 1'b1;
            produced.push_back(word);
         end
      end
      if (record) begin
         foreach (produced[i]) expected_words.push_back(produced[i]);
      end
   endtask

   // Presents one word after a random gap and returns at the edge that takes it.
   task automatic send_word(input logic func, input logic [3:0] cols);
      int unsigned gap;
      gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= func;
      req_columns <= cols;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic csr_write(input int index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= kpd_pkg::CSR_ADDR_W'(index * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (index)
         kpd_pkg::REG_FIRST_DELAY: cfg_first_delay = value[23:0];
         kpd_pkg::REG_REPEAT_STEP: cfg_repeat_step = value[15:0];
         kpd_pkg::REG_HOLD_INC:    cfg_hold_inc    = value[7:0];
         default:                  ;
      endcase
      @(posedge clock);
   endtask

   task automatic csr_check(input int index, input string name);
      logic [31:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= kpd_pkg::CSR_ADDR_W'(index * 4);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      compare_field(name, register_value(index), got);
      @(posedge clock);
   endtask

   task automatic check_registers();
      csr_check(kpd_pkg::REG_FIRST_DELAY, "first_repeat_delay");
      csr_check(kpd_pkg::REG_REPEAT_STEP, "repeat_step");
      csr_check(kpd_pkg::REG_HOLD_INC, "hold_increment");
   endtask

   // Registers change only with the scanner idle: all words drained, then a pause.
   task automatic program_registers(input logic [23:0] first_delay, input logic [15:0] step,
                                    input logic [7:0] hold_inc, input bit poke_unmapped);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(kpd_pkg::REG_FIRST_DELAY, {8'($urandom_range(0, 255)), first_delay});
      csr_write(kpd_pkg::REG_REPEAT_STEP, {16'($urandom), step});
      csr_write(kpd_pkg::REG_HOLD_INC, {24'($urandom), hold_inc});
      if (poke_unmapped) begin
         csr_write(UNMAPPED_REG, $urandom);
      end
      check_registers();
   endtask

   // Random words follow a held-key pattern so that keys debounce and repeat,
   // with occasional bounce and fully random columns.
   task automatic send_random_item();
      logic       func;
      logic [3:0] cols;
      int         idx;
      int         pick;
      pick = $urandom_range(0, 99);
      if (pick < 1) begin
         keys_held = 16'($urandom);
      end else if (pick < 13) begin
         idx = $urandom_range(0, NUM_KEYS - 1);
         keys_held[idx] = ~keys_held[idx];
      end
      func = ($urandom_range(0, 4) == 0) ? FUNC_DRIVE : FUNC_SCAN;
      cols = ~keys_held[driven_row * 4 +: 4];
      pick = $urandom_range(0, 99);
      if (func == FUNC_DRIVE || pick < 6) begin
         cols = 4'($urandom);
      end else if (pick < 16) begin
         cols = cols ^ (4'b0001 << $urandom_range(0, 3));
      end
      send_word(func, cols);
      predict_item(func, cols, 1'b1);
   endtask

   initial begin
      directed_row_type row;
      logic [23:0]      first_delay;
      logic [15:0]      step;
      logic [7:0]       hold_inc;
      int               p;
      int               n;

      reset_scanner_model();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      check_registers();

      // Directed table.
      for (n = 0; n < DIRECTED_COUNT; n++) begin
         row = DIRECTED_ROWS[n];
         send_word(row.func, row.columns);
         predict_item(row.func, row.columns, !row.typed);
         if (row.typed) begin
            expected_words.push_back(idle_word(row.want_row));
         end
      end

      // Random phases, each under its own register setting.
      keys_held = 16'h5555;
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               // Zero threshold: every held key repeats on every pass.
               first_delay = '0;
               step        = '0;
               hold_inc    = 8'hFF;
            end
            1: begin
               first_delay = TIME_SAT;
               step        = 16'hFFFF;
               hold_inc    = '0;
            end
            2: begin
               first_delay = 24'($urandom_range(1, 48));
               step        = 16'($urandom_range(0, 24));
               hold_inc    = 8'($urandom_range(1, 12));
            end
            3: begin
               first_delay = 24'($urandom);
               step        = 16'($urandom);
               hold_inc    = 8'($urandom);
            end
            4: begin
               first_delay = 24'($urandom_range(0, 16));
               step        = 16'($urandom_range(0, 8));
               hold_inc    = 8'($urandom_range(4, 32));
            end
            default: begin
               first_delay = 24'($urandom_range(0, 600));
               step        = 16'($urandom_range(0, 100));
               hold_inc    = 8'($urandom_range(128, 255));
            end
         endcase
         program_registers(first_delay, step, hold_inc, p == 1);
         sender_quiet   = (p == 2) || (p == 5);
         receiver_quiet = (p == 3) || (p == 5);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            send_random_item();
         end
      end

      // Drain the remaining words, then allow the block to settle.
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: matrix_keypad_scan_repeat_top.f
+incdir+rtl/core
rtl/core/kpd_pkg.sv
rtl/core/kpd_csr.sv
rtl/core/kpd_ctrl.sv
rtl/core/kpd_dp.sv
rtl/core/matrix_keypad_scan_repeat_top.sv
test/tb_matrix_keypad_scan_repeat_top.sv
